// ===== hw/rtl/rgb_to_hsl_pixel_assert.svh =====
// assertion macros shared by the rgb to hsl checker
`ifndef RGB_TO_HSL_PIXEL_ASSERT_SVH
`define RGB_TO_HSL_PIXEL_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define RGBHSL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define RGBHSL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/rgbhsl_pkg.sv =====
// shared widths and types for the rgb to hsl pixel converter
package rgbhsl_pkg;

   // one color channel and the lightness field
   localparam int CHAN_W     = 8;
   // hue numerator and divisor (six times the channel spread, below 1536)
   localparam int HNUM_W     = 11;
   // hue and saturation result fields
   localparam int FIELD_W    = 17;
   // packed stream payloads
   localparam int IN_DATA_W  = 24;
   localparam int OUT_DATA_W = 48;
   localparam int PAD_W      = OUT_DATA_W - 2 * FIELD_W - CHAN_W;

   // which channel holds the maximum
   typedef enum logic [1:0] {
      SEL_RED,
      SEL_GREEN,
      SEL_BLUE
   } max_sel_type;

endpackage

// ===== hw/rtl/rgb_to_hsl_pixel.sv =====
// rgb to hsl pixel converter: min/max, setup, then one quotient bit per stage
//
//  channel | direction | payload
//  req     | in        | tdata: red, green, blue; tlast: last pixel of the run
//  rsp     | out       | tdata: hue, saturation, lightness; tlast: copy of input tlast
//
// one pixel accepted per clock while the output is not stalled;
// depth is set by the two restoring dividers, one quotient bit per stage
// every stage carries a valid bit; empty stages fill while the output is stalled
// reset clears the valid bits only; the payload registers are not reset
module rgb_to_hsl_pixel #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // red [7:0], green [15:8], blue [23:16]
   input  logic [rgbhsl_pkg::IN_DATA_W-1:0]    req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // hue [16:0], saturation [33:17], lightness [41:34], zero [47:42]
   output logic [rgbhsl_pkg::OUT_DATA_W-1:0]   rsp_tdata,
   output logic                                rsp_tlast
);
   import rgbhsl_pkg::*;

   localparam int NDIV = FRAC_BITS + 1;
   localparam int LAST = NDIV + 1;
   localparam int NSTG = LAST + 1;

   // stage control
   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] valid_in;
   logic [NSTG-1:0] adv;

   // a stage loads when it is empty or its contents move on
   assign adv[LAST] = !valid_ff[LAST] || rsp_tready;
   for (genvar i = 0; i < LAST; i++) begin : g_adv
      assign adv[i] = !valid_ff[i] || adv[i+1];
   end

   assign valid_in[0] = adv[0] ? req_tvalid : valid_ff[0];
   for (genvar i = 1; i < NSTG; i++) begin : g_valid
      assign valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = adv[0];

   // stage 0: max, min and the channel that wins
   logic [CHAN_W-1:0] red_in, green_in, blue_in;
   logic [CHAN_W-1:0] mx_in, mn_in;
   max_sel_type       sel_in;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;
   logic [CHAN_W-1:0] mx_ff, mn_ff;
   max_sel_type       sel_ff;
   logic              last0_ff;

   assign red_in   = req_tdata[CHAN_W-1:0];
   assign green_in = req_tdata[2*CHAN_W-1:CHAN_W];
   assign blue_in  = req_tdata[3*CHAN_W-1:2*CHAN_W];

   always_comb begin
      mx_in = red_in;
      mn_in = red_in;
      if (green_in > mx_in) mx_in = green_in;
      if (blue_in > mx_in) mx_in = blue_in;
      if (green_in < mn_in) mn_in = green_in;
      if (blue_in < mn_in) mn_in = blue_in;
      // ties: red before green before blue
      if (red_in == mx_in) begin
         sel_in = SEL_RED;
      end else if (green_in == mx_in) begin
         sel_in = SEL_GREEN;
      end else begin
         sel_in = SEL_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         mx_ff    <= mx_in;
         mn_ff    <= mn_in;
         sel_ff   <= sel_in;
         last0_ff <= req_tlast;
      end
   end

   // stage 1: spread, sum, dividends and divisors
   logic [CHAN_W-1:0] d_w;
   logic [CHAN_W:0]   sum_w;
   logic [HNUM_W-1:0] d11_w;
   logic [HNUM_W-1:0] hden_in, hnum_in;
   logic [CHAN_W-1:0] sden_in;
   logic [HNUM_W-1:0] hnum1_ff, hden1_ff;
   logic [CHAN_W-1:0] snum1_ff, sden1_ff, light1_ff;
   logic              zero1_ff, last1_ff;

   assign d_w     = mx_ff - mn_ff;
   assign sum_w   = {1'b0, mx_ff} + {1'b0, mn_ff};
   assign d11_w   = HNUM_W'(d_w);
   assign hden_in = (d11_w << 2) + (d11_w << 1);
   assign sden_in = (sum_w < (CHAN_W+1)'(255)) ? sum_w[CHAN_W-1:0]
                                              : CHAN_W'((CHAN_W+1)'(510) - sum_w);

   // hue numerator, always in [0, 6d) so modulo arithmetic is exact
   always_comb begin
      case (sel_ff)
         SEL_RED: begin
            if (green_ff >= blue_ff) begin
               hnum_in = HNUM_W'(green_ff) - HNUM_W'(blue_ff);
            end else begin
               hnum_in = hden_in - (HNUM_W'(blue_ff) - HNUM_W'(green_ff));
            end
         end
         SEL_GREEN: hnum_in = (d11_w << 1) + HNUM_W'(blue_ff) - HNUM_W'(red_ff);
         SEL_BLUE:  hnum_in = (d11_w << 2) + HNUM_W'(red_ff) - HNUM_W'(green_ff);
         default:   hnum_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         hnum1_ff  <= hnum_in;
         hden1_ff  <= hden_in;
         snum1_ff  <= d_w;
         sden1_ff  <= sden_in;
         light1_ff <= sum_w[CHAN_W:1];
         zero1_ff  <= (d_w == '0);
         last1_ff  <= last0_ff;
      end
   end

   // divider stages, one quotient bit each for hue and saturation
   logic [HNUM_W-1:0] hrem_ff  [NDIV];
   logic [HNUM_W-1:0] hden_ff  [NDIV];
   logic [CHAN_W-1:0] srem_ff  [NDIV];
   logic [CHAN_W-1:0] sden_ff  [NDIV];
   logic [FRAC_BITS:0] hq_ff   [NDIV];
   logic [FRAC_BITS:0] sq_ff   [NDIV];
   logic [CHAN_W-1:0] light_ff [NDIV];
   logic              zero_ff  [NDIV];
   logic              last_ff  [NDIV];

   for (genvar k = 0; k < NDIV; k++) begin : g_div
      logic [HNUM_W:0]    hcand;
      logic [CHAN_W:0]    scand;
      logic [HNUM_W-1:0]  hden_src;
      logic [CHAN_W-1:0]  sden_src;
      logic [FRAC_BITS:0] hq_src, sq_src;
      logic [CHAN_W-1:0]  light_src;
      logic               zero_src, last_src;
      logic               hbit, sbit;
      logic [HNUM_W-1:0]  hrem_in;
      logic [CHAN_W-1:0]  srem_in;

      if (k == 0) begin : g_first
         // first bit compares the dividend itself
         assign hcand     = {1'b0, hnum1_ff};
         assign scand     = {1'b0, snum1_ff};
         assign hden_src  = hden1_ff;
         assign sden_src  = sden1_ff;
         assign hq_src    = '0;
         assign sq_src    = '0;
         assign light_src = light1_ff;
         assign zero_src  = zero1_ff;
         assign last_src  = last1_ff;
      end else begin : g_next
         // later bits shift the partial remainder up
         assign hcand     = {hrem_ff[k-1], 1'b0};
         assign scand     = {srem_ff[k-1], 1'b0};
         assign hden_src  = hden_ff[k-1];
         assign sden_src  = sden_ff[k-1];
         assign hq_src    = hq_ff[k-1];
         assign sq_src    = sq_ff[k-1];
         assign light_src = light_ff[k-1];
         assign zero_src  = zero_ff[k-1];
         assign last_src  = last_ff[k-1];
      end

      assign hbit    = hcand >= {1'b0, hden_src};
      assign sbit    = scand >= {1'b0, sden_src};
      assign hrem_in = hbit ? HNUM_W'(hcand - {1'b0, hden_src}) : hcand[HNUM_W-1:0];
      assign srem_in = sbit ? CHAN_W'(scand - {1'b0, sden_src}) : scand[CHAN_W-1:0];

      always_ff @(posedge clock) begin
         if (adv[k+2]) begin
            hrem_ff[k]  <= hrem_in;
            srem_ff[k]  <= srem_in;
            hden_ff[k]  <= hden_src;
            sden_ff[k]  <= sden_src;
            hq_ff[k]    <= {hq_src[FRAC_BITS-1:0], hbit};
            sq_ff[k]    <= {sq_src[FRAC_BITS-1:0], sbit};
            light_ff[k] <= light_src;
            zero_ff[k]  <= zero_src;
            last_ff[k]  <= last_src;
         end
      end
   end

   // result fields; a gray pixel gives zero hue and saturation
   logic [FIELD_W-1:0] hue_w, sat_w;

   assign hue_w = zero_ff[NDIV-1] ? '0 : FIELD_W'(hq_ff[NDIV-1]);
   assign sat_w = zero_ff[NDIV-1] ? '0 : FIELD_W'(sq_ff[NDIV-1]);

   assign rsp_tvalid = valid_ff[LAST];
   assign rsp_tdata  = {{PAD_W{1'b0}}, light_ff[NDIV-1], sat_w, hue_w};
   assign rsp_tlast  = last_ff[NDIV-1];

endmodule

// ===== hw/rtl/rgbhsl_checker.sv =====
// port-level checker for the rgb to hsl pixel converter, with its bind
`include "rgb_to_hsl_pixel_assert.svh"

module rgbhsl_checker #(
   parameter int FRAC_BITS = 16
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rgbhsl_pkg::OUT_DATA_W-1:0] rsp_tdata,
   input logic                              rsp_tlast
);
   import rgbhsl_pkg::*;

   localparam logic [31:0] ONE_VAL = 32'(1) << FRAC_BITS;

   logic [FIELD_W-1:0] hue_w, sat_w;

   assign hue_w = rsp_tdata[FIELD_W-1:0];
   assign sat_w = rsp_tdata[2*FIELD_W-1:FIELD_W];

   // a stalled transaction holds its payload
   `RGBHSL_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp changed while stalled")

   // an empty output stage means every stage can load
   `RGBHSL_ASSERT_NOW(a_ready_when_empty, !rsp_tvalid, req_tready,
      "input stalled with an empty pipeline")

   // zero saturation only comes from a gray pixel, which has zero hue
   `RGBHSL_ASSERT_NOW(a_gray_hue, rsp_tvalid && (sat_w == '0), hue_w == '0,
      "hue set on a gray pixel")

   // hue stays below one whole turn
   `RGBHSL_ASSERT_NOW(a_hue_range, rsp_tvalid,
      (FRAC_BITS > FIELD_W - 1) || (32'(hue_w) < ONE_VAL), "hue reached 1.0")

endmodule

bind rgb_to_hsl_pixel rgbhsl_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);
